>>> hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted during reset.
`define BFA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, muted during reset.
`define BFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/bfa_pkg.sv
`timescale 1ns / 1ps
package bfa_pkg;

   localparam int HEAP_BYTES    = 1048576;
   localparam int MAX_BLOCKS    = 64;
   localparam int HEADER_BYTES  = 32;
   localparam int INITIAL_BYTES = 131072;
   localparam int ALIGN_BYTES   = 8;

   localparam int OFF_W  = $clog2(HEAP_BYTES);
   localparam int SIZE_W = OFF_W + 1;
   localparam int IDX_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int REQ_W  = 32;
   localparam int PAD_W  = REQ_W + 1;
   localparam int SUM_W  = PAD_W + 1;
   localparam int LIM_W  = 21;
   localparam int CSR_IDX_W = 2;

   // smallest remainder worth splitting off: align(1 + header)
   localparam int MIN_REST =
      ((1 + HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

   localparam logic [LIM_W-1:0] LIMIT_PLAIN_RST  = LIM_W'(131072);
   localparam logic [LIM_W-1:0] LIMIT_ZEROED_RST = LIM_W'(4096);

   typedef enum logic [1:0] {
      K_PLAIN  = 2'd0,
      K_ZEROED = 2'd1,
      K_FREE   = 2'd2,
      K_RSVD   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_LARGE   = 2'd1,
      ST_NOMEM   = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIMIT_PLAIN  = 2'd0,
      CSR_LIMIT_ZEROED = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MRG_START,
      S_MRG,
      S_MRG_END,
      S_DECIDE,
      S_SHIFT,
      S_SPLIT,
      S_SPLIT_LO,
      S_FREE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [OFF_W-1:0]  off;
      logic [SIZE_W-1:0] size;
      logic              free;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

>>> hdl/bfa_req_if.sv
`timescale 1ns / 1ps
interface bfa_req_if import bfa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       kind;
   logic [REQ_W-1:0] request_bytes;
   logic [OFF_W-1:0] payload_offset_in;

   modport source (output valid, kind, request_bytes, payload_offset_in, input ready);
   modport sink   (input valid, kind, request_bytes, payload_offset_in, output ready);
endinterface

>>> hdl/bfa_rsp_if.sv
`timescale 1ns / 1ps
interface bfa_rsp_if import bfa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OFF_W-1:0] payload_offset;
   logic [1:0]       status;

   modport source (output valid, payload_offset, status, input ready);
   modport sink   (input valid, payload_offset, status, output ready);
endinterface

>>> hdl/bfa_csr_if.sv
`timescale 1ns / 1ps
interface bfa_csr_if import bfa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [LIM_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/bfa_ram.sv
`timescale 1ns / 1ps
module bfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/best_fit_block_allocator.sv
`timescale 1ns / 1ps
// Best-fit block allocator over a growable heap, block table kept in one RAM.
// req_if  : one word per request: kind (plain / zeroed allocate, free),
//           request_bytes, payload_offset_in.
// rsp_if  : one word per request: payload_offset, status.
// csr_if  : limit register writes (index 0 plain, 1 zeroed); always ready,
//           to be written only while no request is in flight.
// Allocate: merges adjacent free blocks while scanning the table for the best
// fit, then decides and loads the result; a split first moves every block
// above the chosen one up by one, top down, then writes the two halves.
// A large allocate on an empty heap skips the scan. A free scans from entry 0
// until the matching block or the end of the table. Zero size, unknown kind
// or free on an empty heap is answered without a table scan.
// The table RAM has a single, registered read port, read one entry per cycle
// during a scan. One request is in work at a time;
// req_if.ready is high only while the sequencer is idle.
// The result sits in an output register; a stalled receiver does not block
// the next request, which runs until its own result must be loaded.
// Reset (synchronous, active high) empties the heap: block count and heap
// top go to zero and the limits return to 131072 / 4096; the RAM keeps
// stale entries, but entries at or above the block count are never used.
module best_fit_block_allocator import bfa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bfa_req_if.sink   req_if,
   bfa_rsp_if.source rsp_if,
   bfa_csr_if.sink   csr_if
);
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SIZE_W-1:0] top_ff, top_in;
   logic [LIM_W-1:0]  lim_plain_ff, lim_plain_in;
   logic [LIM_W-1:0]  lim_zero_ff, lim_zero_in;

   logic [PAD_W-1:0]  padded_ff, padded_in;
   logic [LIM_W-1:0]  limit_ff, limit_in;
   logic [OFF_W-1:0]  payload_ff, payload_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   entry_type         pend_ff, pend_in;
   logic              pend_vld_ff, pend_vld_in;
   entry_type         best_ff, best_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic              found_ff, found_in;
   entry_type         last_ff, last_in;
   logic [OFF_W-1:0]  res_off_ff, res_off_in;
   status_type        res_st_ff, res_st_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]  rsp_off_ff, rsp_off_in;
   status_type        rsp_st_ff, rsp_st_in;

   // table RAM ports
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   entry_type         mem_wdata;
   logic [IDX_W-1:0]  mem_raddr;
   logic [ENTRY_W-1:0] mem_rdata;
   entry_type         rd_entry;

   logic              req_fire;
   logic [PAD_W-1:0]  pad_calc;
   logic [PAD_W-1:0]  pad_sum;
   logic [LIM_W-1:0]  lim_sel;
   logic              pend_fits;
   logic              merge_join;
   logic [SUM_W-1:0]  grow_top;
   logic [SUM_W-1:0]  append_top;
   logic              split_ok;
   logic              free_hit;
   logic [CNT_W-1:0]  rd_next;

   bfa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rd_entry = entry_type'(mem_rdata);
   assign req_fire = req_if.valid && req_if.ready;

   // pad by header, round up to alignment
   assign pad_sum  = {1'b0, req_if.request_bytes}
                   + PAD_W'(HEADER_BYTES + ALIGN_BYTES - 1);
   assign pad_calc = pad_sum & ~PAD_W'(ALIGN_BYTES - 1);
   assign lim_sel  = (req_if.kind == K_PLAIN) ? lim_plain_ff : lim_zero_ff;

   // best-fit test on an entry as it leaves the merge stage
   assign pend_fits  = pend_ff.free && (PAD_W'(pend_ff.size) >= padded_ff)
                     && (!found_ff || (best_ff.size > pend_ff.size));
   assign merge_join = pend_vld_ff && pend_ff.free && rd_entry.free;
   assign rd_next    = CNT_W'(rd_idx_ff) + CNT_W'(1);

   assign grow_top   = SUM_W'(top_ff) + SUM_W'(padded_ff) - SUM_W'(last_ff.size);
   assign append_top = SUM_W'(top_ff) + SUM_W'(padded_ff);
   assign split_ok   = (SUM_W'(best_ff.size) >= SUM_W'(padded_ff) + SUM_W'(MIN_REST))
                     && (count_ff < CNT_W'(MAX_BLOCKS));
   assign free_hit   = ((SIZE_W'(rd_entry.off) + SIZE_W'(HEADER_BYTES))
                        == SIZE_W'(payload_ff)) && !rd_entry.free;

   assign csr_if.ready     = 1'b1;
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.payload_offset = rsp_off_ff;
   assign rsp_if.status         = rsp_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         top_ff       <= '0;
         lim_plain_ff <= LIMIT_PLAIN_RST;
         lim_zero_ff  <= LIMIT_ZEROED_RST;
         rsp_valid_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         lim_plain_ff <= lim_plain_in;
         lim_zero_ff  <= lim_zero_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_vld_ff  <= pend_vld_in;
         found_ff     <= found_in;
      end
      padded_ff   <= padded_in;
      limit_ff    <= limit_in;
      payload_ff  <= payload_in;
      rd_idx_ff   <= rd_idx_in;
      wr_idx_ff   <= wr_idx_in;
      pend_ff     <= pend_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      last_ff     <= last_in;
      res_off_ff  <= res_off_in;
      res_st_ff   <= res_st_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_st_ff   <= rsp_st_in;
   end

   // limit registers
   always_comb begin
      lim_plain_in = lim_plain_ff;
      lim_zero_in  = lim_zero_ff;
      if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            CSR_LIMIT_PLAIN:  lim_plain_in = csr_if.data;
            CSR_LIMIT_ZEROED: lim_zero_in  = csr_if.data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      padded_in    = padded_ff;
      limit_in     = limit_ff;
      payload_in   = payload_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      pend_in      = pend_ff;
      pend_vld_in  = pend_vld_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      found_in     = found_ff;
      last_in      = last_ff;
      res_off_in   = res_off_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_off_in   = rsp_off_ff;
      rsp_st_in    = rsp_st_ff;
      mem_we       = 1'b0;
      mem_waddr    = wr_idx_ff;
      mem_wdata    = pend_ff;
      mem_raddr    = rd_idx_ff;
      req_if.ready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_if.ready = 1'b1;
            if (req_fire) begin
               res_off_in = '0;
               payload_in = req_if.payload_offset_in;
               unique case (req_if.kind) inside
                  K_PLAIN, K_ZEROED: begin
                     if (req_if.request_bytes == '0) begin
                        res_st_in = ST_INVALID;
                        state_in  = S_RESP;
                     end else begin
                        padded_in = pad_calc;
                        limit_in  = lim_sel;
                        state_in  = S_MRG_START;
                        // empty heap: claim the initial free block
                        if ((count_ff == '0) && (pad_calc < PAD_W'(lim_sel))) begin
                           mem_we    = 1'b1;
                           mem_waddr = '0;
                           mem_wdata = '{off: '0, size: SIZE_W'(INITIAL_BYTES),
                                         free: 1'b1};
                           count_in  = CNT_W'(1);
                           top_in    = SIZE_W'(INITIAL_BYTES);
                        end
                     end
                  end
                  K_FREE: begin
                     rd_idx_in = '0;
                     mem_raddr = '0;
                     if (count_ff == '0) begin
                        res_st_in = ST_INVALID;
                        state_in  = S_RESP;
                     end else begin
                        state_in  = S_FREE;
                     end
                  end
                  default: begin
                     res_st_in = ST_INVALID;
                     state_in  = S_RESP;
                  end
               endcase
            end
         end

         S_MRG_START: begin
            found_in    = 1'b0;
            pend_vld_in = 1'b0;
            wr_idx_in   = '0;
            rd_idx_in   = '0;
            mem_raddr   = '0;
            state_in    = (count_ff == '0) ? S_DECIDE : S_MRG;
         end

         // rd_entry holds entry rd_idx; pend is the open merged block at wr_idx
         S_MRG: begin
            mem_raddr = IDX_W'(rd_next);
            if (merge_join) begin
               pend_in.size = pend_ff.size + rd_entry.size;
            end else begin
               if (pend_vld_ff) begin
                  mem_we    = 1'b1;
                  wr_idx_in = wr_idx_ff + IDX_W'(1);
                  if (pend_fits) begin
                     best_in     = pend_ff;
                     best_idx_in = wr_idx_ff;
                     found_in    = 1'b1;
                  end
               end
               pend_in     = rd_entry;
               pend_vld_in = 1'b1;
            end
            if (rd_next == count_ff) begin
               state_in = S_MRG_END;
            end else begin
               rd_idx_in = IDX_W'(rd_next);
            end
         end

         S_MRG_END: begin
            mem_we   = 1'b1;
            count_in = CNT_W'(wr_idx_ff) + CNT_W'(1);
            last_in  = pend_ff;
            if (pend_fits) begin
               best_in     = pend_ff;
               best_idx_in = wr_idx_ff;
               found_in    = 1'b1;
            end
            state_in = S_DECIDE;
         end

         S_DECIDE: begin
            state_in = S_RESP;
            if (!found_ff && (count_ff != '0) && last_ff.free) begin
               // grow the free last block to the padded size
               if (grow_top > SUM_W'(HEAP_BYTES)) begin
                  res_st_in = ST_NOMEM;
               end else begin
                  top_in    = SIZE_W'(grow_top);
                  mem_we    = 1'b1;
                  mem_waddr = IDX_W'(count_ff - CNT_W'(1));
                  mem_wdata = '{off: last_ff.off, size: SIZE_W'(padded_ff), free: 1'b0};
                  res_off_in = last_ff.off + OFF_W'(HEADER_BYTES);
                  res_st_in  = ST_OK;
               end
            end else if (!found_ff) begin
               if (padded_ff >= PAD_W'(limit_ff)) begin
                  res_st_in = ST_LARGE;
               end else if ((count_ff >= CNT_W'(MAX_BLOCKS))
                            || (append_top > SUM_W'(HEAP_BYTES))) begin
                  res_st_in = ST_NOMEM;
               end else begin
                  mem_we     = 1'b1;
                  mem_waddr  = IDX_W'(count_ff);
                  mem_wdata  = '{off: OFF_W'(top_ff), size: SIZE_W'(padded_ff),
                                 free: 1'b0};
                  count_in   = count_ff + CNT_W'(1);
                  top_in     = SIZE_W'(append_top);
                  res_off_in = OFF_W'(top_ff) + OFF_W'(HEADER_BYTES);
                  res_st_in  = ST_OK;
               end
            end else if (split_ok) begin
               if ((CNT_W'(best_idx_ff) + CNT_W'(1)) < count_ff) begin
                  rd_idx_in = IDX_W'(count_ff - CNT_W'(1));
                  mem_raddr = IDX_W'(count_ff - CNT_W'(1));
                  state_in  = S_SHIFT;
               end else begin
                  state_in  = S_SPLIT;
               end
            end else begin
               mem_we     = 1'b1;
               mem_waddr  = best_idx_ff;
               mem_wdata  = '{off: best_ff.off, size: best_ff.size, free: 1'b0};
               res_off_in = best_ff.off + OFF_W'(HEADER_BYTES);
               res_st_in  = ST_OK;
            end
         end

         // move entries above the chosen block up by one, top down
         S_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = rd_idx_ff + IDX_W'(1);
            mem_wdata = rd_entry;
            if (rd_idx_ff == (best_idx_ff + IDX_W'(1))) begin
               state_in = S_SPLIT;
            end else begin
               rd_idx_in = rd_idx_ff - IDX_W'(1);
               mem_raddr = rd_idx_ff - IDX_W'(1);
            end
         end

         S_SPLIT: begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_ff + IDX_W'(1);
            mem_wdata = '{off: best_ff.off + OFF_W'(padded_ff),
                          size: best_ff.size - SIZE_W'(padded_ff), free: 1'b1};
            state_in  = S_SPLIT_LO;
         end

         S_SPLIT_LO: begin
            mem_we     = 1'b1;
            mem_waddr  = best_idx_ff;
            mem_wdata  = '{off: best_ff.off, size: SIZE_W'(padded_ff), free: 1'b0};
            count_in   = count_ff + CNT_W'(1);
            res_off_in = best_ff.off + OFF_W'(HEADER_BYTES);
            res_st_in  = ST_OK;
            state_in   = S_RESP;
         end

         S_FREE: begin
            mem_raddr = IDX_W'(rd_next);
            if (free_hit) begin
               mem_we    = 1'b1;
               mem_waddr = rd_idx_ff;
               mem_wdata = '{off: rd_entry.off, size: rd_entry.size, free: 1'b1};
               res_st_in = ST_OK;
               state_in  = S_RESP;
            end else if (rd_next == count_ff) begin
               res_st_in = ST_INVALID;
               state_in  = S_RESP;
            end else begin
               rd_idx_in = IDX_W'(rd_next);
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_off_in   = res_off_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end
endmodule

>>> hdl/bfa_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bfa_checker import bfa_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OFF_W-1:0] rsp_offset,
   input logic [1:0]       rsp_status
);
   // a result waiting on the receiver stays offered
   `BFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // one request in work at a time
   `BFA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // anything but a grant carries a zero offset
   `BFA_ASSERT_IMPL(a_fail_zero, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_offset == '0)

   // a granted payload lies past its header
   `BFA_ASSERT_IMPL(a_grant_past_hdr, clock, reset, rsp_valid && (rsp_status == ST_OK) && (rsp_offset != '0), rsp_offset >= OFF_W'(HEADER_BYTES))
endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_offset (rsp_if.payload_offset),
   .rsp_status (rsp_if.status)
);

>>> dv/tb_ifs.sv
`timescale 1ns / 1ps
// Testbench-side view: the channel interfaces come from the RTL tree.
// This file holds the helper types shared by the testbench top.
package tb_alloc_pkg;
   import bfa_pkg::*;

   typedef struct {
      logic [1:0]       kind;
      logic [REQ_W-1:0] request_bytes;
      logic [OFF_W-1:0] payload_offset_in;
   } alloc_word_type;

   typedef struct {
      logic [OFF_W-1:0] payload_offset;
      logic [1:0]       status;
   } grant_word_type;
endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import bfa_pkg::*;
   import tb_alloc_pkg::*;

   logic clock;
   logic reset;

   bfa_req_if req_if ();
   bfa_rsp_if rsp_if ();
   bfa_csr_if csr_if ();

   best_fit_block_allocator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Shadow heap: block table, count, top and the two limits.
   // ---------------------------------------------------------------
   logic [OFF_W-1:0]  sh_off  [MAX_BLOCKS];
   logic [SIZE_W-1:0] sh_size [MAX_BLOCKS];
   logic              sh_free [MAX_BLOCKS];
   int unsigned       sh_count = 0;
   longint unsigned   sh_top = 0;
   logic [LIM_W-1:0]  lim_plain;
   logic [LIM_W-1:0]  lim_zeroed;

   alloc_word_type pending_words[$];
   grant_word_type expected_grants[$];
   int             fail_count = 0;
   int             send_idle_pct;
   int             recv_idle_pct;
   bit             hold_active = 1'b0;   // long receiver hold-off in progress
   event           hold_go;
   longint         cycle_count = 0;

   // adjacent free blocks fold into the lower one
   function automatic void merge_free_runs();
      int unsigned w;
      w = 0;
      for (int unsigned r = 0; r < sh_count; r++) begin
         if (w > 0 && sh_free[w-1] && sh_free[r]) begin
            sh_size[w-1] = sh_size[w-1] + sh_size[r];
         end else begin
            sh_off[w]  = sh_off[r];
            sh_size[w] = sh_size[r];
            sh_free[w] = sh_free[r];
            w++;
         end
      end
      sh_count = w;
   endfunction

   // claims block i, splitting off the tail when it is worth a block of its own
   function automatic void claim_block(int unsigned i, longint unsigned padded);
      if (longint'(sh_size[i]) >= MIN_REST + padded && sh_count < MAX_BLOCKS) begin
         for (int k = int'(sh_count) - 1; k > int'(i); k--) begin
            sh_off[k+1]  = sh_off[k];
            sh_size[k+1] = sh_size[k];
            sh_free[k+1] = sh_free[k];
         end
         sh_off[i+1]  = sh_off[i] + OFF_W'(padded);
         sh_size[i+1] = sh_size[i] - SIZE_W'(padded);
         sh_free[i+1] = 1'b1;
         sh_size[i]   = SIZE_W'(padded);
         sh_count++;
      end
      sh_free[i] = 1'b0;
   endfunction

   function automatic grant_word_type predict_grant(alloc_word_type w);
      grant_word_type  g;
      longint unsigned padded, limit, grow;
      int unsigned     best;
      bit              found;
      g.payload_offset = '0;
      g.status = ST_INVALID;
      best = 0;
      found = 0;
      if (w.kind == K_FREE) begin
         for (int unsigned i = 0; i < sh_count; i++) begin
            if (longint'(sh_off[i]) + HEADER_BYTES == longint'(w.payload_offset_in)
                && !sh_free[i]) begin
               sh_free[i] = 1'b1;
               g.status = ST_OK;
               return g;
            end
         end
         return g;
      end
      if (w.kind != K_PLAIN && w.kind != K_ZEROED) return g;
      if (w.request_bytes == 0) return g;
      padded = ((longint'(w.request_bytes) + HEADER_BYTES + ALIGN_BYTES - 1)
                / ALIGN_BYTES) * ALIGN_BYTES;
      limit = (w.kind == K_PLAIN) ? lim_plain : lim_zeroed;
      if (sh_count == 0 && padded < limit) begin
         sh_off[0] = '0;
         sh_size[0] = SIZE_W'(INITIAL_BYTES);
         sh_free[0] = 1'b1;
         sh_count = 1;
         sh_top = INITIAL_BYTES;
      end
      merge_free_runs();
      for (int unsigned i = 0; i < sh_count; i++) begin
         if (sh_free[i] && longint'(sh_size[i]) >= padded) begin
            if (!found || sh_size[best] > sh_size[i]) begin
               best = i;
               found = 1;
            end
         end
      end
      if (!found && sh_count > 0 && sh_free[sh_count-1]) begin
         grow = padded - sh_size[sh_count-1];
         if (sh_top + grow > HEAP_BYTES) begin
            g.status = ST_NOMEM;
            return g;
         end
         sh_top += grow;
         sh_size[sh_count-1] = SIZE_W'(padded);
         best = sh_count - 1;
         found = 1;
      end
      if (!found) begin
         if (padded >= limit) begin
            g.status = ST_LARGE;
            return g;
         end
         if (sh_count >= MAX_BLOCKS || sh_top + padded > HEAP_BYTES) begin
            g.status = ST_NOMEM;
            return g;
         end
         best = sh_count;
         sh_off[best]  = OFF_W'(sh_top);
         sh_size[best] = SIZE_W'(padded);
         sh_free[best] = 1'b0;
         sh_count++;
         sh_top += padded;
      end else begin
         claim_block(best, padded);
      end
      g.payload_offset = OFF_W'(longint'(sh_off[best]) + HEADER_BYTES);
      g.status = ST_OK;
      return g;
   endfunction

   // payload offsets handed out and not yet released, for well-formed frees
   logic [OFF_W-1:0] live_payloads[$];

   // ---------------------------------------------------------------
   // Driver: one word per accepted handshake, fed from pending_words.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            alloc_word_type w;
            w.kind = req_if.kind;
            w.request_bytes = req_if.request_bytes;
            w.payload_offset_in = req_if.payload_offset_in;
            expected_grants.push_back(predict_grant(w));
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               alloc_word_type n;
               n = pending_words.pop_front();
               req_if.valid             <= 1'b1;
               req_if.kind              <= n.kind;
               req_if.request_bytes     <= n.request_bytes;
               req_if.payload_offset_in <= n.payload_offset_in;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted in its own process
   always begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (3000) @(posedge clock);
      hold_active <= 1'b0;
   end

   // ---------------------------------------------------------------
   // Monitor: checks each result word against the oldest expectation.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_grants.size() == 0) begin
               $error("result word with nothing expected");
               fail_count++;
            end else begin
               grant_word_type e;
               e = expected_grants.pop_front();
               if (rsp_if.status !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, rsp_if.status);
                  fail_count++;
               end
               if (rsp_if.payload_offset !== e.payload_offset) begin
                  $error("payload_offset: expected %0h, actual %0h",
                         e.payload_offset, rsp_if.payload_offset);
                  fail_count++;
               end
               if (e.status == ST_OK && e.payload_offset != 0)
                  live_payloads.push_back(e.payload_offset);
            end
         end
         if (hold_active) begin
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 3000000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // wait until driver queue is drained and every expectation is met;
   // checked mid-cycle so the driver's updates have settled
   task automatic drain_all();
      while (pending_words.size() > 0 || req_if.valid || expected_grants.size() > 0)
         @(negedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_limit(csr_index_type idx, logic [LIM_W-1:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      if (idx == CSR_LIMIT_PLAIN) lim_plain = val;
      else lim_zeroed = val;
      @(posedge clock);
   endtask

   function automatic alloc_word_type mk(logic [1:0] k, logic [31:0] b,
                                         logic [OFF_W-1:0] p);
      alloc_word_type w;
      w.kind = k;
      w.request_bytes = b;
      w.payload_offset_in = p;
      return w;
   endfunction

   // random size: mostly small, some mid, rare huge
   function automatic logic [31:0] rand_size();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(1, 600);
      if (r < 90) return $urandom_range(600, 40000);
      if (r < 97) return $urandom_range(40000, 300000);
      return $urandom();
   endfunction

   // one phase of random traffic; frees target live blocks most of the time
   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         int r;
         r = $urandom_range(99);
         if (r < 55) begin
            pending_words.push_back(mk($urandom_range(1) ? K_ZEROED : K_PLAIN,
                                       rand_size(), OFF_W'($urandom())));
         end else if (r < 90 && live_payloads.size() > 0) begin
            int j;
            j = $urandom_range(live_payloads.size() - 1);
            pending_words.push_back(mk(K_FREE, $urandom(), live_payloads[j]));
            live_payloads.delete(j);
         end else if (r < 97) begin
            pending_words.push_back(mk(K_FREE, $urandom(), OFF_W'($urandom())));
         end else begin
            pending_words.push_back(mk(K_RSVD, $urandom(), OFF_W'($urandom())));
         end
         // pace the queue so frees see recent grants
         while (pending_words.size() > 4) @(posedge clock);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_LIMIT_PLAIN;
      csr_if.data = '0;
      lim_plain = LIMIT_PLAIN_RST;
      lim_zeroed = LIMIT_ZEROED_RST;
      send_idle_pct = 14;
      recv_idle_pct = 76;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero size, unknown kind, unknown free, empty heap, large
      pending_words.push_back(mk(K_PLAIN, 32'd0, '0));
      pending_words.push_back(mk(K_RSVD, 32'hFFFF_FFFF, '1));
      pending_words.push_back(mk(K_FREE, 32'd0, OFF_W'(HEADER_BYTES)));
      pending_words.push_back(mk(K_ZEROED, 32'd5000, '0));    // large on empty heap
      pending_words.push_back(mk(K_PLAIN, 32'd1, '0));        // creates initial block
      pending_words.push_back(mk(K_PLAIN, 32'd100, '0));
      pending_words.push_back(mk(K_ZEROED, 32'd200, '0));
      pending_words.push_back(mk(K_FREE, 32'd0, OFF_W'(HEADER_BYTES)));
      pending_words.push_back(mk(K_FREE, 32'd0, OFF_W'(HEADER_BYTES))); // double free
      pending_words.push_back(mk(K_PLAIN, 32'd200000, '0));   // grows last block
      pending_words.push_back(mk(K_PLAIN, 32'd900000, '0));   // above the plain limit
      pending_words.push_back(mk(K_PLAIN, 32'hFFFF_FFFF, '0));
      pending_words.push_back(mk(K_ZEROED, 32'hFFFF_FFFF, '0));
      pending_words.push_back(mk(K_FREE, 32'hFFFF_FFFF, '1));
      drain_all();

      // long receiver stall while the sender keeps offering
      -> hold_go;
      for (int i = 0; i < 12; i++)
         pending_words.push_back(mk(K_PLAIN, $urandom_range(1, 64), '0));
      drain_all();

      random_phase(160);
      drain_all();

      // limits at extremes, then the other idling mix
      write_limit(CSR_LIMIT_PLAIN, '0);
      write_limit(CSR_LIMIT_ZEROED, LIM_W'(1048576));
      send_idle_pct = 76;
      recv_idle_pct = 14;
      random_phase(60);
      // many tiny blocks to fill the table
      for (int i = 0; i < 70; i++)
         pending_words.push_back(mk(K_ZEROED, $urandom_range(1, 8), '0));
      drain_all();

      write_limit(CSR_LIMIT_PLAIN, '1);
      write_limit(CSR_LIMIT_ZEROED, LIM_W'(8));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(120);
      drain_all();

      write_limit(CSR_LIMIT_PLAIN, LIM_W'(131072));
      write_limit(CSR_LIMIT_ZEROED, LIM_W'(4096));
      random_phase(100);
      drain_all();

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
